// ----- hw/rtl/ctc_pkg.sv -----
// Shared types and constants for the close tuple counter.
`default_nettype none

package ctc_pkg;

    localparam int VALUE_W    = 32;
    localparam int DELTA_W    = 31;
    localparam int CSIZE_W    = 3;
    localparam int TOTAL_W    = 58;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;
    localparam int OUT_W      = 64;

    localparam logic [TOTAL_W-1:0] TOTAL_CAP = {TOTAL_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_DELTA  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIQUE = 1'b1;

    localparam logic [DELTA_W-1:0] DELTA_RESET  = 31'd16777;
    localparam logic [CSIZE_W-1:0] CLIQUE_RESET = 3'd3;

    // request to the binomial unit
    typedef struct packed {
        logic               start;
        logic [CSIZE_W-1:0] r;
    } binom_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ctc_binom.sv -----
// Iterative saturating binomial coefficient unit, C(m, r) with r up to 7.
`default_nettype none

module ctc_binom
    import ctc_pkg::*;
#(
    parameter int M_W = 11
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire binom_req_t         req,
    input  wire logic [M_W-1:0]     m,
    output logic                    done,
    output logic [TOTAL_W-1:0]      result
);

    localparam int F_W = (M_W > 6) ? M_W : 7;
    localparam int P_W = TOTAL_W + F_W;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_MUL  = 3'b010,
        B_DIV  = 3'b100
    } bstate_t;

    bstate_t              state_reg, state_next;
    logic                 done_reg, done_next;
    logic [TOTAL_W-1:0]   result_reg, result_next;
    logic [TOTAL_W-1:0]   acc_reg, acc_next;
    logic [M_W-1:0]       m_reg, m_next;
    logic [CSIZE_W-1:0]   r_reg, r_next;
    logic [CSIZE_W-1:0]   i_reg, i_next;
    logic [63:0]          div_reg, div_next;
    logic [2:0]           rem_reg, rem_next;
    logic [2:0]           cnt_reg, cnt_next;

    logic [F_W-1:0]       factor;
    logic [P_W-1:0]       prod;
    logic [CSIZE_W-1:0]   divisor;
    logic [3:0]           rem_w;
    logic [7:0]           qbits;
    logic [63:0]          quot;
    logic                 ge;

    assign factor  = F_W'(m_reg) - F_W'(i_reg);
    assign prod    = P_W'(acc_reg) * P_W'(factor);
    assign divisor = i_reg + 3'd1;

    // eight bits of long division by a small divisor per cycle
    always_comb
    begin
        rem_w = {1'b0, rem_reg};
        qbits = '0;
        ge    = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            rem_w = {rem_w[2:0], div_reg[63-k]};
            ge    = (rem_w >= {1'b0, divisor});
            if (ge)
            begin
                rem_w = rem_w - {1'b0, divisor};
            end
            qbits[7-k] = ge;
        end
    end

    assign quot = {div_reg[55:0], qbits};

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        acc_next    = acc_reg;
        m_next      = m_reg;
        r_next      = r_reg;
        i_next      = i_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (req.start)
                begin
                    m_next   = m;
                    r_next   = req.r;
                    i_next   = '0;
                    acc_next = TOTAL_W'(1);
                    if (F_W'(req.r) > F_W'(m))
                    begin
                        result_next = '0;
                        done_next   = 1'b1;
                    end
                    else if (req.r == '0)
                    begin
                        result_next = TOTAL_W'(1);
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = B_MUL;
                    end
                end
            end
            B_MUL:
            begin
                if (prod[P_W-1:64] != '0)
                begin
                    result_next = TOTAL_CAP;
                    done_next   = 1'b1;
                    state_next  = B_IDLE;
                end
                else
                begin
                    div_next   = prod[63:0];
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                div_next = quot;
                rem_next = rem_w[2:0];
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    if (quot[63:TOTAL_W] != '0)
                    begin
                        result_next = TOTAL_CAP;
                        done_next   = 1'b1;
                        state_next  = B_IDLE;
                    end
                    else if (divisor == r_reg)
                    begin
                        result_next = quot[TOTAL_W-1:0];
                        done_next   = 1'b1;
                        state_next  = B_IDLE;
                    end
                    else
                    begin
                        acc_next   = quot[TOTAL_W-1:0];
                        i_next     = divisor;
                        state_next = B_MUL;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        acc_reg    <= acc_next;
        m_reg      <= m_next;
        r_reg      <= r_next;
        i_reg      <= i_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/close_tuple_counter_core.sv -----
// Top level of the close tuple counter: stream ports, value store and control.
`default_nettype none

// Counts subsets of clique_size values whose spread is at most delta in a
// stream of non-decreasing signed fixed-point values. Each accepted value is
// taken as the largest member of a subset: a tail pointer walks the value
// store (one synchronous RAM, MAX_ITEMS x 32) forward to the earliest entry
// v with v + delta >= value, and C(m, clique_size - 1) is added to a
// saturating 58-bit total, m being the number of stored values from the
// tail on. Items are processed one at a time. Each item walks the tail, each
// tail step being a RAM read plus compare, then waits on the binomial unit,
// which spends a multiply and a long division on each of its r factors,
// r = clique_size - 1 (seven when clique_size is zero). The final compare is
// skipped when the tail reaches the head, the binomial unit answers at once
// when r exceeds m, and it stops early once the count saturates. Items that
// arrive after an overflow go straight from idle to the finish state. On the
// item flagged by s_tlast the total, an order error flag and an overflow flag
// are placed in the output register and the set is cleared; the next item is
// accepted while that result waits. delta and clique_size are to be written
// through the cfg port only while the block is idle; the block does not enforce this.

module close_tuple_counter_core
    import ctc_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // config write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input request stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [VALUE_W-1:0]    s_tdata,   // [31:0] value
    input  wire logic                  s_tlast,   // last value of the set
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_W-1:0]           m_tdata    // [57:0] total, [58] order_error,
                                                  // [59] overflow, [63:60] zero
);

    localparam int HEAD_W = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = $clog2(MAX_ITEMS);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_READ   = 5'b00010,
        ST_CMP    = 5'b00100,
        ST_BINOM  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t               state_reg, state_next;

    // configuration
    logic [DELTA_W-1:0]   delta_reg, delta_next;
    logic [CSIZE_W-1:0]   clique_reg, clique_next;

    // per-set state
    logic [HEAD_W-1:0]    head_reg, head_next;
    logic [HEAD_W-1:0]    tail_reg, tail_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [VALUE_W-1:0]   prev_reg, prev_next;
    logic                 order_reg, order_next;
    logic                 ovf_reg, ovf_next;

    // current item
    logic [VALUE_W-1:0]   v_reg, v_next;
    logic                 last_reg, last_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;

    // value store
    logic [VALUE_W-1:0]   value_store [MAX_ITEMS];
    logic [VALUE_W-1:0]   rd_data_reg;
    logic                 mem_we;

    // binomial unit
    binom_req_t           breq;
    logic                 bdone;
    logic [TOTAL_W-1:0]   bresult;
    logic [HEAD_W-1:0]    span;

    logic                 in_fire;
    logic                 tail_advance;
    logic [33:0]          stored_ext;
    logic [33:0]          v_ext;
    logic [TOTAL_W:0]     sum;
    logic                 load_out;

    assign in_fire    = s_tvalid && s_tready;
    assign span       = head_reg - tail_reg;
    assign stored_ext = {{2{rd_data_reg[VALUE_W-1]}}, rd_data_reg} + {3'b000, delta_reg};
    assign v_ext      = {{2{v_reg[VALUE_W-1]}}, v_reg};
    // stored + delta below the new value: entry falls out of the window
    assign tail_advance = $signed(stored_ext) < $signed(v_ext);
    assign sum        = {1'b0, total_reg} + {1'b0, bresult};

    ctc_binom #(
        .M_W (HEAD_W)
    ) u_binom (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (breq),
        .m      (span),
        .done   (bdone),
        .result (bresult)
    );

    // config writes
    always_comb
    begin
        delta_next  = delta_reg;
        clique_next = clique_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DELTA:  delta_next  = cfg_data[DELTA_W-1:0];
                CFG_CLIQUE: clique_next = cfg_data[CSIZE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        total_next     = total_reg;
        prev_next      = prev_reg;
        order_next     = order_reg;
        ovf_next       = ovf_reg;
        v_next         = v_reg;
        last_next      = last_reg;
        out_data_next  = out_data_reg;
        breq.start     = 1'b0;
        breq.r         = clique_reg - 3'd1;
        mem_we         = 1'b0;
        load_out       = 1'b0;
        s_tready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (in_fire)
                begin
                    v_next    = s_tdata;
                    last_next = s_tlast;
                    if (ovf_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (head_reg == HEAD_W'(MAX_ITEMS))
                    begin
                        ovf_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        if (head_reg != '0 && $signed(s_tdata) < $signed(prev_reg))
                        begin
                            order_next = 1'b1;
                        end
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // RAM read of the tail entry is issued at this edge
                if (tail_reg < head_reg)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    breq.start = 1'b1;
                    state_next = ST_BINOM;
                end
            end
            ST_CMP:
            begin
                if (tail_advance)
                begin
                    tail_next  = tail_reg + HEAD_W'(1);
                    state_next = ST_READ;
                end
                else
                begin
                    breq.start = 1'b1;
                    state_next = ST_BINOM;
                end
            end
            ST_BINOM:
            begin
                if (bdone)
                begin
                    if (clique_reg != '0)
                    begin
                        total_next = sum[TOTAL_W] ? TOTAL_CAP : sum[TOTAL_W-1:0];
                    end
                    mem_we     = 1'b1;
                    head_next  = head_reg + HEAD_W'(1);
                    prev_next  = v_reg;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    load_out      = 1'b1;
                    out_data_next = {4'b0000, ovf_reg, order_reg, total_reg};
                    head_next     = '0;
                    tail_next     = '0;
                    total_next    = '0;
                    prev_next     = '0;
                    order_next    = 1'b0;
                    ovf_next      = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !m_tready) || load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            delta_reg     <= DELTA_RESET;
            clique_reg    <= CLIQUE_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            total_reg     <= '0;
            prev_reg      <= '0;
            order_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            delta_reg     <= delta_next;
            clique_reg    <= clique_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            total_reg     <= total_next;
            prev_reg      <= prev_next;
            order_reg     <= order_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    // value store: write at head, registered read at tail
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            value_store[head_reg[ADDR_W-1:0]] <= v_reg;
        end
        rd_data_reg <= value_store[tail_reg[ADDR_W-1:0]];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- tb/close_tuple_counter_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for close_tuple_counter_core: sorted and unsorted sets checked against a scoreboard.

module close_tuple_counter_core_tb
    import ctc_pkg::*;
();

    localparam int MAX_ITEMS    = 1024;
    localparam int DRAIN        = 128;     // cycles left for the block to settle
    localparam int STALL_LIMIT  = 20000;   // cycles without any handshake before giving up
    localparam int RANDOM_ITEMS = 250;

    localparam logic [DELTA_W-1:0] DELTA_MAX = {DELTA_W{1'b1}};
    localparam longint unsigned    CAP64     = {{(64-TOTAL_W){1'b0}}, TOTAL_CAP};

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               order_error;
        logic               overflow;
    } tuple_result_t;

    // Scoreboard: keeps a private copy of the value store and pointers and
    // predicts the total of every set as its last request is accepted.
    class tuple_count_board;
        logic [DELTA_W-1:0]        delta_reg;
        logic [CSIZE_W-1:0]        size_reg;
        logic signed [VALUE_W-1:0] values [MAX_ITEMS];
        int unsigned               head;
        int unsigned               tail;
        longint unsigned           count;
        logic signed [VALUE_W-1:0] prev_value;
        bit                        order_seen;
        bit                        over_seen;
        tuple_result_t             totals_due [$];
        int                        errors     = 0;
        int                        checked    = 0;
        int                        order_sets = 0;
        int                        over_sets  = 0;

        function new();
            delta_reg = DELTA_RESET;
            size_reg  = CLIQUE_RESET;
            clear();
        endfunction

        function void clear();
            head       = 0;
            tail       = 0;
            count      = 0;
            prev_value = '0;
            order_seen = 0;
            over_seen  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_DELTA)
                delta_reg = data[DELTA_W-1:0];
            else if (idx == CFG_CLIQUE)
                size_reg = data[CSIZE_W-1:0];
        endfunction

        function int pending();
            return totals_due.size();
        endfunction

        // m choose r, saturating at the total's cap
        function longint unsigned choose_capped(longint unsigned m, int unsigned r);
            longint unsigned acc;
            longint unsigned f;
            acc = 1;
            if (r > m)
                return 0;
            for (int unsigned i = 0; i < r; i++)
            begin
                f = m - i;
                if (acc > 64'hFFFF_FFFF_FFFF_FFFF / f)
                    return CAP64;
                acc = acc * f / (i + 1);
                if (acc > CAP64)
                    return CAP64;
            end
            return acc;
        endfunction

        function void take_value(logic [VALUE_W-1:0] word, logic last);
            longint          v;
            longint          low;
            longint unsigned add;
            tuple_result_t   res;
            v = longint'($signed(word));
            if (!over_seen)
            begin
                if (head >= MAX_ITEMS)
                    over_seen = 1;
                else
                begin
                    if (head > 0 && v < longint'(prev_value))
                        order_seen = 1;
                    // tail only moves forward, even after an out-of-order value
                    while (tail < head)
                    begin
                        low = longint'(values[tail]) + longint'({1'b0, delta_reg});
                        if (low >= v)
                            break;
                        tail++;
                    end
                    if (size_reg != 0)
                    begin
                        add   = choose_capped(longint'(head - tail), size_reg - 1);
                        count = count + add;
                        if (count > CAP64)
                            count = CAP64;
                    end
                    values[head] = word;
                    head++;
                    prev_value = word;
                end
            end
            if (last)
            begin
                res.total       = count[TOTAL_W-1:0];
                res.order_error = order_seen;
                res.overflow    = over_seen;
                totals_due.push_back(res);
                clear();
            end
        endfunction

        function void check_total(logic [OUT_W-1:0] word);
            tuple_result_t want;
            if (totals_due.size() == 0)
            begin
                errors++;
                $error("unexpected result: total %0d order_error %0b overflow %0b",
                       word[TOTAL_W-1:0], word[TOTAL_W], word[TOTAL_W+1]);
                return;
            end
            want = totals_due.pop_front();
            checked++;
            if (want.order_error)
                order_sets++;
            if (want.overflow)
                over_sets++;
            if (word[TOTAL_W-1:0] !== want.total)
            begin
                errors++;
                $error("total: expected %0d, actual %0d", want.total, word[TOTAL_W-1:0]);
            end
            if (word[TOTAL_W] !== want.order_error)
            begin
                errors++;
                $error("order_error: expected %0b, actual %0b", want.order_error, word[TOTAL_W]);
            end
            if (word[TOTAL_W+1] !== want.overflow)
            begin
                errors++;
                $error("overflow: expected %0b, actual %0b", want.overflow, word[TOTAL_W+1]);
            end
            if (word[OUT_W-1:TOTAL_W+2] !== '0)
            begin
                errors++;
                $error("pad: expected 0, actual %0h", word[OUT_W-1:TOTAL_W+2]);
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    wire                   s_tready;
    logic [VALUE_W-1:0]    s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    wire                   m_tvalid;
    logic                  m_tready  = 1'b0;
    wire  [OUT_W-1:0]      m_tdata;

    tuple_count_board board;
    bit               no_idle      = 0;   // phases where neither side inserts gaps
    int               items_sent   = 0;
    int               writes       = 0;
    int               stall_cycles = 0;

    close_tuple_counter_core #(
        .MAX_ITEMS (MAX_ITEMS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int unsigned gap_len();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned set_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 12);
        if (r < 95)
            return $urandom_range(13, 40);
        return $urandom_range(41, 120);
    endfunction

    // One request on the input stream; the scoreboard notes it at the accepting edge.
    task automatic send_item(logic [VALUE_W-1:0] word, logic last);
        int unsigned gap;
        gap = gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= last;
        do @(posedge clk); while (s_tready !== 1'b1);
        board.take_value(word, last);
        items_sent++;
    endtask

    // Drops tvalid so nothing is accepted twice while the sender waits.
    task automatic idle_sender();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.set_reg(idx, data);
        writes++;
    endtask

    // Clique size with random junk above the 3 used bits.
    task automatic write_clique(logic [CSIZE_W-1:0] size);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data[CSIZE_W-1:0] = size;
        write_reg(CFG_CLIQUE, data);
    endtask

    // Waits out every pending total, then lets the block settle.
    task automatic drain_results();
        idle_sender();
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic new_setting();
        logic [DELTA_W-1:0] d;
        logic [CSIZE_W-1:0] c;
        int unsigned        which;
        drain_results();
        case ($urandom_range(0, 5))
            0:       d = '0;
            1:       d = DELTA_MAX;
            2:       d = DELTA_RESET;
            3:       d = DELTA_W'($urandom_range(0, 1 << 20));
            4:       d = DELTA_W'($urandom_range(0, 1 << 26));
            default: d = DELTA_W'($urandom);
        endcase
        c = ($urandom_range(0, 15) == 0) ? 3'd0 : CSIZE_W'($urandom_range(1, 7));
        which = $urandom_range(0, 3);
        if (which != 1)
            write_reg(CFG_DELTA, d);
        if (which != 2)
            write_clique(c);
    endtask

    // A set of non-decreasing values with steps scaled to delta; noisy sets
    // carry the odd random value, which usually breaks the order.
    task automatic send_set(int unsigned len, bit noisy);
        longint             cur;
        longint             step;
        logic [VALUE_W-1:0] word;
        int unsigned        r;
        int unsigned        d;
        d = {1'b0, board.delta_reg};
        if ($urandom_range(0, 19) == 0)
            cur = -64'sd2147483648;
        else if ($urandom_range(0, 1) != 0)
            cur = longint'($signed($urandom));
        else
            cur = longint'($urandom_range(0, 2000)) - 1000;
        for (int unsigned n = 0; n < len; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                step = 0;
            else if (r < 70)
                step = longint'($urandom_range(0, d));
            else if (r < 95)
                step = longint'($urandom_range(0, d)) * $urandom_range(2, 4) + 1;
            else
                step = longint'($urandom);
            if (n > 0)
                cur = cur + step;
            if (cur > 64'sd2147483647)
                cur = 64'sd2147483647;
            word = cur[VALUE_W-1:0];
            if (noisy && $urandom_range(0, 24) == 0)
                word = $urandom;
            send_item(word, n == len - 1);
        end
    endtask

    // Result side: ready toggles with random stalls.
    initial
    begin
        int unsigned stall;
        int unsigned hold;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = gap_len();
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            hold = $urandom_range(1, 8);
            repeat (hold)
            begin
                @(negedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            board.check_total(m_tdata);
    end

    // Watchdog: any accepted transfer on either stream resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int  random_start;
        bit  forced_pause;
        board = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, reset settings first: lowest value alone, equal
        // values and the edge of delta, the highest value, then a drop in order.
        send_item(32'h8000_0000, 1'b1);
        send_item(32'd0, 1'b0);
        send_item(32'd0, 1'b0);
        send_item(32'd16777, 1'b0);
        send_item(32'd16778, 1'b0);
        send_item(32'd33555, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b1);
        send_item(32'd1000, 1'b0);
        send_item(32'd500, 1'b0);
        send_item(32'd500, 1'b1);

        // clique size zero counts nothing
        drain_results();
        write_clique(3'd0);
        write_reg(CFG_DELTA, DELTA_MAX);
        send_item(32'd5, 1'b0);
        send_item(32'd6, 1'b0);
        send_item(32'd7, 1'b1);

        // subsets of one value: every value counts once, whatever the spread
        drain_results();
        write_reg(CFG_DELTA, '0);
        write_clique(3'd1);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b1);

        // largest subsets, widest delta across the whole value range
        drain_results();
        write_reg(CFG_DELTA, DELTA_MAX);
        write_clique(3'd7);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h8000_0001, 1'b0);
        send_item(32'hC000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h4000_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b1);

        // Full store: one set that fills every entry, overflows, sends
        // ignored requests after it and puts the last flag on an ignored one.
        drain_results();
        write_reg(CFG_DELTA, CFG_DATA_W'($urandom_range(0, 1 << 22)));
        write_clique(3'd2);
        send_set(MAX_ITEMS + 3, 1'b0);

        // Random phases; each starts from idle with fresh values in one or both registers.
        random_start = items_sent;
        forced_pause = 1;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            new_setting();
            no_idle = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(3, 10))
            begin
                send_set(set_len(), 1'b1);
                // now and then, and after the first set, hold the sender until every pending total has come back
                if (forced_pause || $urandom_range(0, 9) == 0)
                begin
                    idle_sender();
                    while (board.pending() != 0) @(posedge clk);
                    forced_pause = 0;
                end
            end
        end
        no_idle = 0;

        drain_results();
        $display("Run covered %0d requests, %0d sets checked, %0d register writes.",
                 items_sent, board.checked, writes);
        $display("Sets with order error: %0d, sets with overflow: %0d.",
                 board.order_sets, board.over_sets);
        if (board.errors == 0 && board.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ctc_pkg.sv
hw/rtl/ctc_binom.sv
hw/rtl/close_tuple_counter_core.sv
tb/close_tuple_counter_core_tb.sv
